### rtl/rlcd_pkg.sv
// ----------------------------------------------------------------------------
// rlcd_pkg
// shared types, constants and the decimal power table of the run-length
// compressor with decimal run counts
// ----------------------------------------------------------------------------
package rlcd_pkg;

	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 16;
	localparam int NUM_POW    = 5;
	localparam int POW_IDX_W  = 3;
	localparam int DIGIT_W    = 4;

	localparam logic [POW_IDX_W-1:0] ONES_IDX   = POW_IDX_W'(NUM_POW - 1);
	localparam logic [BYTE_W-1:0]    ASCII_ZERO = 8'h30;
	localparam logic [CNT_W-1:0]     CNT_SAT    = {CNT_W{1'b1}};

	// result of one step of the shared compare/subtract unit
	typedef struct packed {
		logic             ge;
		logic [CNT_W-1:0] diff;
	} digit_res_t;

	// power of ten for each digit place, most significant first
	function automatic logic [CNT_W-1:0] pow10(input logic [POW_IDX_W-1:0] idx);
		logic [CNT_W-1:0] p;
		unique case (idx)
			3'd0:    p = 16'd10000;
			3'd1:    p = 16'd1000;
			3'd2:    p = 16'd100;
			3'd3:    p = 16'd10;
			default: p = 16'd1;
		endcase
		return p;
	endfunction

endpackage

### rtl/rlcd_digit_unit.sv
// ----------------------------------------------------------------------------
// rlcd_digit_unit
// shared compare and subtract unit: tests the remainder against the power of
// ten of the current digit place and forms the reduced remainder
// ----------------------------------------------------------------------------
module rlcd_digit_unit
	import rlcd_pkg::*;
(
	input  logic [CNT_W-1:0]     rem,
	input  logic [POW_IDX_W-1:0] idx,
	output digit_res_t           res
);

	logic [CNT_W-1:0] pow;
	logic [CNT_W:0]   sub;

	assign pow      = pow10(idx);
	assign sub      = {1'b0, rem} - {1'b0, pow};
	assign res.ge   = ~sub[CNT_W];
	assign res.diff = sub[CNT_W-1:0];

endmodule

### rtl/run_length_compressor_decimal_core.sv
// ----------------------------------------------------------------------------
// run_length_compressor_decimal_core
// streaming run-length compressor that writes run lengths as ascii decimal
// ----------------------------------------------------------------------------
// Each input item is one message byte (s_tdata) with an end-of-message mark
// (s_tlast). The core holds the open run's byte and length. A byte that
// differs from the run, or any byte once the run has reached MAX_RUN, closes
// the run: the core sends the run byte and, for runs longer than one, the
// length in ascii decimal digits, most significant first, without leading
// zeros. On s_tlast the open run is flushed the same way and m_tlast marks the
// final output item; the per-message output count (saturating at 65535)
// travels with every output item and restarts after each message. Timing: an
// item that only extends or opens a run leaves s_tready high, so the next item
// can follow at once. Closing a run first sends the run byte and, when the
// length n is above one, walks the five digit places, subtracting one unit of
// each digit of n at a time, all in a single shared compare/subtract unit that
// strips powers of ten from the length; a flush that closes two runs does both
// closes in turn. s_tready stays low while a close is in progress, and each
// output item also waits for the one-deep output register to be free.
// ----------------------------------------------------------------------------
module run_length_compressor_decimal_core
	import rlcd_pkg::*;
#(
	parameter int MAX_RUN = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] total_length
	output logic        m_tlast    // out_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAR,
		ST_DIGIT
	} state_t;

	state_t               state_q;
	logic [BYTE_W-1:0]    run_char_q;
	logic [CNT_W-1:0]     run_count_q;
	logic [CNT_W-1:0]     emitted_q;
	// run being closed; cl_cnt_q doubles as the digit remainder
	logic [BYTE_W-1:0]    cl_char_q;
	logic [CNT_W-1:0]     cl_cnt_q;
	logic                 final_q;    // this close ends the message
	logic                 pend_q;     // open run must be flushed after this close
	logic [POW_IDX_W-1:0] idx_q;
	logic [DIGIT_W-1:0]   digit_q;
	logic                 started_q;  // a nonzero digit has gone out
	// output register
	logic                 m_tvalid_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_last_q;
	logic [CNT_W-1:0]     total_q;

	logic               accept;
	logic               run_open;
	logic               run_cont;
	logic               slot_free;
	logic               need_digit;
	logic               emit;
	logic [BYTE_W-1:0]  emit_byte;
	logic               emit_last;
	logic               close_done;
	logic [CNT_W-1:0]   cnt_inc;
	digit_res_t         du_res;

	rlcd_digit_unit u_digit (
		.rem (cl_cnt_q),
		.idx (idx_q),
		.res (du_res)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign run_open  = (run_count_q != '0);
	// a run at its limit is closed even by an equal byte
	assign run_cont  = run_open && (s_tdata == run_char_q) && (run_count_q < CNT_W'(MAX_RUN));
	assign slot_free = !m_tvalid_q || m_tready;

	// leading zeros are skipped, the ones place always goes out
	assign need_digit = (digit_q != '0) || started_q || (idx_q == ONES_IDX);

	always_comb begin
		emit       = 1'b0;
		emit_byte  = cl_char_q;
		emit_last  = 1'b0;
		close_done = 1'b0;
		unique case (state_q)
			ST_CHAR: begin
				emit       = slot_free;
				emit_last  = final_q && (cl_cnt_q <= CNT_W'(1));
				close_done = slot_free && (cl_cnt_q <= CNT_W'(1));
			end
			ST_DIGIT: begin
				emit       = !du_res.ge && need_digit && slot_free;
				emit_byte  = ASCII_ZERO + BYTE_W'(digit_q);
				emit_last  = final_q && (idx_q == ONES_IDX);
				close_done = !du_res.ge && (idx_q == ONES_IDX) && slot_free;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign cnt_inc = (emitted_q == CNT_SAT) ? CNT_SAT : emitted_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_char_q  <= '0;
			run_count_q <= '0;
			emitted_q   <= '0;
			cl_char_q   <= '0;
			cl_cnt_q    <= '0;
			final_q     <= 1'b0;
			pend_q      <= 1'b0;
			started_q   <= 1'b0;
			idx_q       <= '0;
			digit_q     <= '0;
			m_tvalid_q  <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			total_q     <= '0;
		end else begin
			// output register
			if (emit) begin
				m_tvalid_q <= 1'b1;
				out_byte_q <= emit_byte;
				out_last_q <= emit_last;
				total_q    <= cnt_inc;
				emitted_q  <= emit_last ? '0 : cnt_inc;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (run_cont && !s_tlast) begin
							run_count_q <= run_count_q + CNT_W'(1);
						end else if (run_cont) begin
							// last byte extends the run, flush it
							cl_char_q   <= run_char_q;
							cl_cnt_q    <= run_count_q + CNT_W'(1);
							final_q     <= 1'b1;
							pend_q      <= 1'b0;
							run_count_q <= '0;
							state_q     <= ST_CHAR;
						end else if (run_open) begin
							// close old run, new byte opens a run
							cl_char_q   <= run_char_q;
							cl_cnt_q    <= run_count_q;
							final_q     <= 1'b0;
							pend_q      <= s_tlast;
							run_char_q  <= s_tdata;
							run_count_q <= CNT_W'(1);
							state_q     <= ST_CHAR;
						end else if (!s_tlast) begin
							run_char_q  <= s_tdata;
							run_count_q <= CNT_W'(1);
						end else begin
							// single-byte message
							run_char_q  <= s_tdata;
							cl_char_q   <= s_tdata;
							cl_cnt_q    <= CNT_W'(1);
							final_q     <= 1'b1;
							pend_q      <= 1'b0;
							run_count_q <= '0;
							state_q     <= ST_CHAR;
						end
					end
				end
				ST_CHAR: begin
					if (slot_free && cl_cnt_q > CNT_W'(1)) begin
						idx_q     <= '0;
						digit_q   <= '0;
						started_q <= 1'b0;
						state_q   <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (du_res.ge) begin
						cl_cnt_q <= du_res.diff;
						digit_q  <= digit_q + DIGIT_W'(1);
					end else if (!need_digit || slot_free) begin
						if (need_digit) begin
							started_q <= 1'b1;
						end
						idx_q   <= idx_q + POW_IDX_W'(1);
						digit_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// end of a close: flush the pending one-byte run or go idle
			if (close_done) begin
				if (pend_q) begin
					cl_char_q   <= run_char_q;
					cl_cnt_q    <= CNT_W'(1);
					final_q     <= 1'b1;
					pend_q      <= 1'b0;
					run_count_q <= '0;
					state_q     <= ST_CHAR;
				end else begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {total_q, out_byte_q};
	assign m_tlast  = out_last_q;

endmodule

### rtl/rlcd_checker.sv
// ----------------------------------------------------------------------------
// rlcd_checker
// port-level checks on the output stream of the run-length compressor
// ----------------------------------------------------------------------------
module rlcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// count includes the item itself
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:8] != 16'd0)
		else $error("output count is zero");

	// count steps by one inside a message, saturating
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
			(m_tdata[23:8] == $past(m_tdata[23:8]) + 16'd1) || (m_tdata[23:8] == 16'hFFFF))
		else $error("output count did not advance by one");

	// count restarts after the last item of a message
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata[23:8] == 16'd1)
		else $error("output count did not restart");

endmodule

bind run_length_compressor_decimal_core rlcd_checker u_rlcd_checker (.*);
